FILE: sv/pvr_pkg.sv
// Shared types, constants and tables for the pose visibility rating unit.
// No dependencies; the rating unit, its submodules and the testbench refer to this package.
package pvr_pkg;

    localparam int CORDIC_STEPS = 17;
    localparam int CORD_W       = 45;
    localparam int ACC_W        = 26;
    localparam int DIV_BITS     = 16;
    localparam int ANGLE_LAT    = CORDIC_STEPS + 3;
    localparam int COS_LAT      = 7;
    localparam int PIPE_LEN     = ANGLE_LAT + 1 + DIV_BITS + COS_LAT;

    typedef logic [15:0]              angle_t;
    typedef logic [15:0]              phase_t;
    typedef logic [15:0]              rating_t;
    typedef logic [30:0]              divword_t;
    typedef logic [28:0]              wsq_t;
    typedef logic signed [CORD_W-1:0] cord_t;
    typedef logic signed [ACC_W-1:0]  angacc_t;
    typedef logic signed [33:0]       horner_t;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_NEAR  = 3'd0,
        REG_FAR   = 3'd1,
        REG_FOV_H = 3'd2,
        REG_FOV_V = 3'd3,
        REG_THR_D = 3'd4,
        REG_THR_A = 3'd5,
        REG_THR_E = 3'd6
    } cfg_reg_t;

    localparam logic [30:0]        NEAR_RESET = 31'd26214;
    localparam logic [30:0]        FAR_RESET  = 31'd98304;
    localparam logic [15:0]        FOV_H_RESET = 16'd15360;
    localparam logic [15:0]        FOV_V_RESET = 16'd11520;
    localparam logic signed [16:0] THR_RESET  = 17'sd0;

    // angle constants in Q8.8 / Q16.16 degrees
    localparam angle_t  ANGLE_RIGHT = 16'd23040;
    localparam angle_t  ANGLE_LIMIT = 16'd46080;
    localparam angacc_t BASE_90     = 26'sd5898240;

    localparam rating_t RATING_ONE  = 16'd32768;

    // atan(2^-i) in Q16.16 degrees
    localparam logic [21:0] ATAN_Q16 [CORDIC_STEPS] = '{
        22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379,
        22'd117304,  22'd58666,   22'd29335,  22'd14668,  22'd7334,
        22'd3667,    22'd1833,    22'd917,    22'd458,    22'd229,
        22'd115,     22'd57
    };

    // Taylor coefficients of cos(pi*sqrt(w)) in Q30
    localparam horner_t COS_Q30 [6] = '{
        34'sd1073741824, -34'sd5298703516, 34'sd4358008962,
        -34'sd1433727482, 34'sd252684340, -34'sd27709939
    };

endpackage

FILE: sv/pvr_in_if.sv
// Pose input channel: valid/ready handshake carrying one camera-frame position.
// No dependencies.
interface pvr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;

    modport source (output valid, output pos_x, output pos_y, output pos_z, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, output ready);
endinterface

FILE: sv/pvr_out_if.sv
// Rating output channel: valid/ready handshake carrying the three ratings and visible.
// No dependencies.
interface pvr_out_if;
    logic        valid;
    logic        ready;
    logic        visible;
    logic [15:0] rating_distance;
    logic [15:0] rating_azimuth;
    logic [15:0] rating_elevation;

    modport source (output valid, output visible, output rating_distance,
                    output rating_azimuth, output rating_elevation, input ready);
    modport sink   (input valid, input visible, input rating_distance,
                    input rating_azimuth, input rating_elevation, output ready);
endinterface

FILE: sv/pvr_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying register index and data.
// No dependencies.
interface pvr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/pose_visibility_rating_unit.sv
// Pose visibility rating unit: throughput one pose per cycle while the output is not stalled.
// An accepted pose passes the 20-stage angle unit (prepare, normalize, 17 CORDIC
// rotations, round), one operand stage, the 16-stage phase divider, the 7-stage raised
// cosine and the output register; a stalled output holds the whole pipeline in place.
// Reset clears all valid bits and restores the configuration registers to their default
// values. Depends on pvr_pkg and the interfaces.
module pose_visibility_rating_unit
(
    input  logic          clk,
    input  logic          rst_n,
    pvr_cfg_if.sink       cfg,
    pvr_in_if.sink        pose,
    pvr_out_if.source     result
);

    localparam int ALAT = pvr_pkg::ANGLE_LAT;
    localparam int PLEN = pvr_pkg::PIPE_LEN;

    logic               adv;
    logic               v_reg [PLEN];
    logic               out_valid_reg;

    logic [30:0]        near_reg;
    logic [30:0]        far_reg;
    logic [15:0]        fov_h_reg;
    logic [15:0]        fov_v_reg;
    logic signed [16:0] thr_d_reg;
    logic signed [16:0] thr_a_reg;
    logic signed [16:0] thr_e_reg;

    logic [31:0]        lat_x;
    logic [31:0]        lat_y;
    pvr_pkg::angle_t    ang_h;
    pvr_pkg::angle_t    ang_v;
    logic signed [31:0] zd_reg [ALAT];

    pvr_pkg::divword_t  num_next [3];
    pvr_pkg::divword_t  den_next [3];
    logic               zero_next[3];
    pvr_pkg::divword_t  num_reg  [3];
    pvr_pkg::divword_t  den_reg  [3];
    logic               zero_reg [3];

    pvr_pkg::phase_t    phase    [3];
    logic               pzero    [3];
    pvr_pkg::rating_t   rate     [3];

    logic               vis_next;
    logic               vis_reg;
    pvr_pkg::rating_t   rd_reg;
    pvr_pkg::rating_t   ra_reg;
    pvr_pkg::rating_t   re_reg;

    // advance whenever the output register is empty or being drained
    assign adv         = !out_valid_reg || result.ready;
    assign pose.ready  = adv;
    assign cfg.ready   = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_reg  <= pvr_pkg::NEAR_RESET;
            far_reg   <= pvr_pkg::FAR_RESET;
            fov_h_reg <= pvr_pkg::FOV_H_RESET;
            fov_v_reg <= pvr_pkg::FOV_V_RESET;
            thr_d_reg <= pvr_pkg::THR_RESET;
            thr_a_reg <= pvr_pkg::THR_RESET;
            thr_e_reg <= pvr_pkg::THR_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                pvr_pkg::REG_NEAR:  near_reg  <= cfg.data[30:0];
                pvr_pkg::REG_FAR:   far_reg   <= cfg.data[30:0];
                pvr_pkg::REG_FOV_H: fov_h_reg <= cfg.data[15:0];
                pvr_pkg::REG_FOV_V: fov_v_reg <= cfg.data[15:0];
                pvr_pkg::REG_THR_D: thr_d_reg <= $signed(cfg.data[16:0]);
                pvr_pkg::REG_THR_A: thr_a_reg <= $signed(cfg.data[16:0]);
                pvr_pkg::REG_THR_E: thr_e_reg <= $signed(cfg.data[16:0]);
                default:            ;
            endcase
        end
    end

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PLEN; k++)
            begin
                v_reg[k] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= pose.valid;
            for (int k = 1; k < PLEN; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
            out_valid_reg <= v_reg[PLEN-1];
        end
    end

    // lateral magnitudes
    assign lat_x = pose.pos_x[31] ? 32'(~pose.pos_x) + 32'd1 : 32'(pose.pos_x);
    assign lat_y = pose.pos_y[31] ? 32'(~pose.pos_y) + 32'd1 : 32'(pose.pos_y);

    pvr_angle u_ang_h
    (
        .clk   (clk),
        .en    (adv),
        .lat   (lat_x),
        .z     (pose.pos_z),
        .angle (ang_h)
    );

    pvr_angle u_ang_v
    (
        .clk   (clk),
        .en    (adv),
        .lat   (lat_y),
        .z     (pose.pos_z),
        .angle (ang_v)
    );

    // hold z alongside the angle pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zd_reg[0] <= pose.pos_z;
            for (int k = 1; k < ALAT; k++)
            begin
                zd_reg[k] <= zd_reg[k-1];
            end
        end
    end

    // phase operands; out-of-range cases divide zero by one and force a zero rating
    always_comb
    begin
        logic [34:0] d2s;
        logic [34:0] d2abs;
        logic [30:0] h2;
        logic        dz;
        d2s   = (35'(zd_reg[ALAT-1]) << 1) - 35'(near_reg) - 35'(far_reg);
        d2abs = d2s[34] ? 35'(~d2s) + 35'd1 : d2s;
        h2    = far_reg - near_reg;
        dz    = !(far_reg > near_reg) || (d2abs >= 35'(h2));
        zero_next[0] = dz;
        num_next[0]  = dz ? '0 : d2abs[30:0];
        den_next[0]  = dz ? 31'd1 : h2;

        zero_next[1] = ang_h >= fov_h_reg;
        num_next[1]  = zero_next[1] ? '0 : 31'(ang_h);
        den_next[1]  = zero_next[1] ? 31'd1 : 31'(fov_h_reg);

        zero_next[2] = ang_v >= fov_v_reg;
        num_next[2]  = zero_next[2] ? '0 : 31'(ang_v);
        den_next[2]  = zero_next[2] ? 31'd1 : 31'(fov_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_reg  <= num_next;
            den_reg  <= den_next;
            zero_reg <= zero_next;
        end
    end

    // one divider and one raised cosine for each rating
    for (genvar g = 0; g < 3; g++)
    begin : g_rate
        pvr_phase_div u_div
        (
            .clk      (clk),
            .en       (adv),
            .num      (num_reg[g]),
            .den      (den_reg[g]),
            .zero_in  (zero_reg[g]),
            .quo      (phase[g]),
            .zero_out (pzero[g])
        );

        pvr_raised_cos u_cos
        (
            .clk     (clk),
            .en      (adv),
            .p       (phase[g]),
            .zero_in (pzero[g]),
            .rating  (rate[g])
        );
    end

    // visible when every rating beats its threshold
    assign vis_next = ($signed({1'b0, rate[0]}) > thr_d_reg) &&
                      ($signed({1'b0, rate[1]}) > thr_a_reg) &&
                      ($signed({1'b0, rate[2]}) > thr_e_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= vis_next;
            rd_reg  <= rate[0];
            ra_reg  <= rate[1];
            re_reg  <= rate[2];
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.visible          = vis_reg;
    assign result.rating_distance  = rd_reg;
    assign result.rating_azimuth   = ra_reg;
    assign result.rating_elevation = re_reg;

endmodule

FILE: sv/pvr_angle.sv
// Pipelined atan2(lat, z) in Q8.8 degrees: prepare, normalize, 17 CORDIC stages, round.
// Depends on pvr_pkg.
module pvr_angle
(
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        lat,
    input  logic signed [31:0] z,
    output pvr_pkg::angle_t    angle
);

    localparam int LAST = pvr_pkg::CORDIC_STEPS;

    logic [31:0] sx_next;
    logic [31:0] sy_next;
    logic [31:0] mx;
    logic [5:0]  sh_next;
    logic        base_next;
    logic        zero_next;

    logic [31:0] s1_x_reg;
    logic [31:0] s1_y_reg;
    logic [5:0]  s1_sh_reg;
    logic        s1_base_reg;
    logic        s1_zero_reg;

    pvr_pkg::cord_t   cx_reg   [LAST+1];
    pvr_pkg::cord_t   cy_reg   [LAST+1];
    pvr_pkg::angacc_t acc_reg  [LAST+1];
    logic             zf_reg   [LAST+1];
    pvr_pkg::cord_t   cx_next  [LAST+1];
    pvr_pkg::cord_t   cy_next  [LAST+1];
    pvr_pkg::angacc_t acc_next [LAST+1];
    logic             zf_next  [LAST+1];

    pvr_pkg::angle_t  angle_next;
    pvr_pkg::angle_t  angle_reg;

    // pick quadrant, detect the zero vector, find the shift that normalizes
    always_comb
    begin
        zero_next = (lat == 32'd0) && (z == 32'sd0);
        base_next = z[31];
        if (z[31])
        begin
            sx_next = lat;
            sy_next = 32'(~z) + 32'd1;
        end
        else
        begin
            sx_next = 32'(z);
            sy_next = lat;
        end
        mx = (sx_next > sy_next) ? sx_next : sy_next;
        sh_next = 6'd40;
        for (int b = 0; b < 32; b++)
        begin
            if (mx[b])
            begin
                sh_next = 6'(40 - b);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_x_reg    <= sx_next;
            s1_y_reg    <= sy_next;
            s1_sh_reg   <= sh_next;
            s1_base_reg <= base_next;
            s1_zero_reg <= zero_next;
        end
    end

    // normalize, then one rotation per stage
    always_comb
    begin
        pvr_pkg::cord_t   xs;
        pvr_pkg::cord_t   ys;
        pvr_pkg::angacc_t da;
        cx_next[0]  = pvr_pkg::cord_t'(pvr_pkg::CORD_W'(s1_x_reg) << s1_sh_reg);
        cy_next[0]  = pvr_pkg::cord_t'(pvr_pkg::CORD_W'(s1_y_reg) << s1_sh_reg);
        acc_next[0] = s1_base_reg ? pvr_pkg::BASE_90 : '0;
        zf_next[0]  = s1_zero_reg;
        for (int i = 0; i < LAST; i++)
        begin
            xs = cx_reg[i] >>> i;
            ys = cy_reg[i] >>> i;
            da = pvr_pkg::angacc_t'(pvr_pkg::ACC_W'(pvr_pkg::ATAN_Q16[i]));
            if (!cy_reg[i][pvr_pkg::CORD_W-1] && (cy_reg[i] != '0))
            begin
                cx_next[i+1]  = cx_reg[i] + ys;
                cy_next[i+1]  = cy_reg[i] - xs;
                acc_next[i+1] = acc_reg[i] + da;
            end
            else
            begin
                cx_next[i+1]  = cx_reg[i] - ys;
                cy_next[i+1]  = cy_reg[i] + xs;
                acc_next[i+1] = acc_reg[i] - da;
            end
            zf_next[i+1] = zf_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg  <= cx_next;
            cy_reg  <= cy_next;
            acc_reg <= acc_next;
            zf_reg  <= zf_next;
        end
    end

    // clamp, round to Q8.8, limit to 180 degrees
    always_comb
    begin
        logic [pvr_pkg::ACC_W-1:0] pos;
        logic [pvr_pkg::ACC_W-1:0] rnd;
        pos = acc_reg[LAST][pvr_pkg::ACC_W-1] ? '0 : acc_reg[LAST];
        rnd = (pos + pvr_pkg::ACC_W'(128)) >> 8;
        if (zf_reg[LAST])
        begin
            angle_next = pvr_pkg::ANGLE_RIGHT;
        end
        else if (rnd > pvr_pkg::ACC_W'(pvr_pkg::ANGLE_LIMIT))
        begin
            angle_next = pvr_pkg::ANGLE_LIMIT;
        end
        else
        begin
            angle_next = rnd[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

FILE: sv/pvr_phase_div.sv
// Pipelined restoring divider: phase = floor(num * 65536 / den), one quotient bit a stage.
// Depends on pvr_pkg.
module pvr_phase_div
(
    input  logic              clk,
    input  logic              en,
    input  pvr_pkg::divword_t num,
    input  pvr_pkg::divword_t den,
    input  logic              zero_in,
    output pvr_pkg::phase_t   quo,
    output logic              zero_out
);

    localparam int N = pvr_pkg::DIV_BITS;

    pvr_pkg::divword_t rem_reg  [N];
    pvr_pkg::divword_t den_reg  [N];
    pvr_pkg::phase_t   quo_reg  [N];
    logic              zero_reg [N];
    pvr_pkg::divword_t rem_next [N];
    pvr_pkg::divword_t den_next [N];
    pvr_pkg::phase_t   quo_next [N];
    logic              zero_next[N];

    // shift the remainder up, subtract the divisor where it fits
    always_comb
    begin
        pvr_pkg::divword_t rs;
        pvr_pkg::divword_t ds;
        pvr_pkg::phase_t   qs;
        logic              zs;
        logic [31:0]       r2;
        for (int k = 0; k < N; k++)
        begin
            if (k == 0)
            begin
                rs = num;
                ds = den;
                qs = '0;
                zs = zero_in;
            end
            else
            begin
                rs = rem_reg[k-1];
                ds = den_reg[k-1];
                qs = quo_reg[k-1];
                zs = zero_reg[k-1];
            end
            r2 = {rs, 1'b0};
            if (r2 >= {1'b0, ds})
            begin
                rem_next[k] = 31'(r2 - {1'b0, ds});
                quo_next[k] = {qs[14:0], 1'b1};
            end
            else
            begin
                rem_next[k] = r2[30:0];
                quo_next[k] = {qs[14:0], 1'b0};
            end
            den_next[k]  = ds;
            zero_next[k] = zs;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            quo_reg  <= quo_next;
            zero_reg <= zero_next;
        end
    end

    assign quo      = quo_reg[N-1];
    assign zero_out = zero_reg[N-1];

endmodule

FILE: sv/pvr_raised_cos.sv
// Pipelined raised cosine 0.5 + 0.5*cos(pi*p/65536) in Q1.15: fold, five Horner steps, round.
// Depends on pvr_pkg.
module pvr_raised_cos
(
    input  logic             clk,
    input  logic             en,
    input  pvr_pkg::phase_t  p,
    input  logic             zero_in,
    output pvr_pkg::rating_t rating
);

    localparam int H = 5;

    logic            neg_next;
    pvr_pkg::phase_t pf;
    logic [31:0]     sq;

    pvr_pkg::wsq_t   f_w_reg;
    logic            f_neg_reg;
    logic            f_zero_reg;

    pvr_pkg::horner_t h_acc_reg  [H];
    pvr_pkg::wsq_t    h_w_reg    [H];
    logic             h_neg_reg  [H];
    logic             h_zero_reg [H];
    pvr_pkg::horner_t h_acc_next [H];
    pvr_pkg::wsq_t    h_w_next   [H];
    logic             h_neg_next [H];
    logic             h_zero_next[H];

    pvr_pkg::rating_t rating_next;
    pvr_pkg::rating_t rating_reg;

    // fold the upper half onto the lower and square the phase
    always_comb
    begin
        neg_next = p > 16'd32768;
        pf = neg_next ? 16'(17'd65536 - {1'b0, p}) : p;
        sq = pf * pf;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_w_reg    <= sq[30:2];
            f_neg_reg  <= neg_next;
            f_zero_reg <= zero_in;
        end
    end

    // Horner steps, one multiply each
    always_comb
    begin
        pvr_pkg::horner_t  as;
        pvr_pkg::wsq_t     ws;
        logic signed [63:0] prod;
        for (int j = 0; j < H; j++)
        begin
            if (j == 0)
            begin
                as = pvr_pkg::COS_Q30[5];
                ws = f_w_reg;
                h_neg_next[j]  = f_neg_reg;
                h_zero_next[j] = f_zero_reg;
            end
            else
            begin
                as = h_acc_reg[j-1];
                ws = h_w_reg[j-1];
                h_neg_next[j]  = h_neg_reg[j-1];
                h_zero_next[j] = h_zero_reg[j-1];
            end
            prod = 64'(as) * 64'($signed({1'b0, ws}));
            h_acc_next[j] = pvr_pkg::COS_Q30[4-j] + pvr_pkg::horner_t'(prod >>> 30);
            h_w_next[j]   = ws;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_acc_reg  <= h_acc_next;
            h_w_reg    <= h_w_next;
            h_neg_reg  <= h_neg_next;
            h_zero_reg <= h_zero_next;
        end
    end

    // clamp to [0, 1], map to Q1.15 and unfold
    always_comb
    begin
        logic [30:0] c;
        logic [31:0] sum;
        if (h_acc_reg[H-1][33])
        begin
            c = '0;
        end
        else if (h_acc_reg[H-1] > 34'sd1073741824)
        begin
            c = 31'd1073741824;
        end
        else
        begin
            c = h_acc_reg[H-1][30:0];
        end
        sum = 32'd1073741824 + 32'(c) + 32'd32768;
        if (h_zero_reg[H-1])
        begin
            rating_next = '0;
        end
        else if (h_neg_reg[H-1])
        begin
            rating_next = pvr_pkg::RATING_ONE - sum[31:16];
        end
        else
        begin
            rating_next = sum[31:16];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rating_reg <= rating_next;
        end
    end

    assign rating = rating_reg;

endmodule

FILE: tb/sv/tb.sv
// Testbench for pose_visibility_rating_unit: drives poses and register writes,
// predicts each rating triple bit for bit and compares the results in order.
// Depends on pvr_pkg and the pvr_in_if, pvr_out_if and pvr_cfg_if interfaces.
module tb;

    typedef struct packed {
        logic        visible;
        logic [15:0] rd;
        logic [15:0] ra;
        logic [15:0] re;
    } rating_set_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pvr_cfg_if cfg ();
    pvr_in_if  pose ();
    pvr_out_if result ();

    pose_visibility_rating_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .pose   (pose),
        .result (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the configuration
    logic [30:0]        near_q, far_q;
    logic [15:0]        fovh_q, fovv_q;
    logic signed [16:0] thr_d, thr_a, thr_e;

    rating_set_t expected_ratings[$];
    int  mismatches = 0;
    int  idle_cycles = 0;
    bit  gaps_on = 1'b1;
    bit  hold_long = 1'b0;
    bit  timed_out = 1'b0;

    localparam longint ATAN_TBL [pvr_pkg::CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57
    };
    localparam longint COS_TBL [6] = '{
        1073741824, -64'sd5298703516, 64'sd4358008962, -64'sd1433727482,
        252684340, -27709939
    };

    function automatic longint floor_sr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic int unsigned cos_rating(int unsigned p);
        longint w, acc;
        if (p > 32768)
            return 32768 - cos_rating(65536 - p);
        w = (longint'(p) * longint'(p)) >>> 2;
        acc = COS_TBL[5];
        for (int k = 4; k >= 0; k--)
            acc = COS_TBL[k] + floor_sr(acc * w, 30);
        if (acc < 0)
            acc = 0;
        if (acc > 64'sd1073741824)
            acc = 64'sd1073741824;
        return int'((64'sd1073741824 + acc + 32768) >>> 16);
    endfunction

    // atan2(lat, z) in Q8.8 degrees by CORDIC vectoring
    function automatic int unsigned view_angle(longint lat, longint z);
        longint x, y, acc, nx, ny, mx;
        if (lat == 0 && z == 0)
            return pvr_pkg::ANGLE_RIGHT;
        acc = 0;
        if (z < 0)
        begin
            x = lat;
            y = -z;
            acc = longint'(90) << 16;
        end
        else
        begin
            x = z;
            y = lat;
        end
        mx = (x > y) ? x : y;
        while (mx < (longint'(1) << 40))
        begin
            mx = mx <<< 1;
            x = x * 2;
            y = y * 2;
        end
        for (int i = 0; i < pvr_pkg::CORDIC_STEPS; i++)
        begin
            if (y > 0)
            begin
                nx = x + floor_sr(y, i);
                ny = y - floor_sr(x, i);
                acc += ATAN_TBL[i];
            end
            else
            begin
                nx = x - floor_sr(y, i);
                ny = y + floor_sr(x, i);
                acc -= ATAN_TBL[i];
            end
            x = nx;
            y = ny;
        end
        if (acc < 0)
            acc = 0;
        acc = (acc + 128) >>> 8;
        if (acc > pvr_pkg::ANGLE_LIMIT)
            acc = pvr_pkg::ANGLE_LIMIT;
        return int'(acc);
    endfunction

    function automatic int unsigned angle_to_rating(int unsigned a, longint lim);
        if (longint'(a) >= lim)
            return 0;
        return cos_rating(int'((longint'(a) << 16) / lim));
    endfunction

    function automatic rating_set_t rate_pose(logic signed [31:0] px,
                                              logic signed [31:0] py,
                                              logic signed [31:0] pz);
        rating_set_t r;
        longint x, y, z, d2, h2;
        int unsigned rd, ra, re;
        x = px;
        y = py;
        z = pz;
        rd = 0;
        if (far_q > near_q)
        begin
            h2 = longint'(far_q) - longint'(near_q);
            d2 = 2 * z - longint'(near_q) - longint'(far_q);
            if (d2 < 0)
                d2 = -d2;
            if (d2 < h2)
                rd = cos_rating(int'((d2 << 16) / h2));
        end
        ra = angle_to_rating(view_angle(x < 0 ? -x : x, z), longint'(fovh_q));
        re = angle_to_rating(view_angle(y < 0 ? -y : y, z), longint'(fovv_q));
        r.visible = (longint'(rd) > thr_d) && (longint'(ra) > thr_a)
                    && (longint'(re) > thr_e);
        r.rd = rd[15:0];
        r.ra = ra[15:0];
        r.re = re[15:0];
        return r;
    endfunction

    // drive one pose transaction and queue its prediction
    task automatic send_pose(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            pose.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pose.valid <= 1'b1;
        pose.pos_x <= px;
        pose.pos_y <= py;
        pose.pos_z <= pz;
        do @(posedge clk); while (!pose.ready);
        expected_ratings.insert(expected_ratings.size(), rate_pose(px, py, pz));
    endtask

    task automatic write_reg(pvr_pkg::cfg_reg_t idx, logic [31:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
        case (idx)
            pvr_pkg::REG_NEAR:  near_q = val[30:0];
            pvr_pkg::REG_FAR:   far_q  = val[30:0];
            pvr_pkg::REG_FOV_H: fovh_q = val[15:0];
            pvr_pkg::REG_FOV_V: fovv_q = val[15:0];
            pvr_pkg::REG_THR_D: thr_d  = val[16:0];
            pvr_pkg::REG_THR_A: thr_a  = val[16:0];
            pvr_pkg::REG_THR_E: thr_e  = val[16:0];
            default: ;
        endcase
    endtask

    task automatic drain;
        pose.valid <= 1'b0;
        while (expected_ratings.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_config(logic [31:0] n, logic [31:0] f, logic [15:0] h,
                              logic [15:0] v, logic [16:0] td, logic [16:0] ta,
                              logic [16:0] te);
        drain();
        write_reg(pvr_pkg::REG_NEAR, n);
        write_reg(pvr_pkg::REG_FAR, f);
        write_reg(pvr_pkg::REG_FOV_H, {16'd0, h});
        write_reg(pvr_pkg::REG_FOV_V, {16'd0, v});
        write_reg(pvr_pkg::REG_THR_D, {{15{td[16]}}, td});
        write_reg(pvr_pkg::REG_THR_A, {{15{ta[16]}}, ta});
        write_reg(pvr_pkg::REG_THR_E, {{15{te[16]}}, te});
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
            2: return 32'($urandom_range(0, 262144));
            default: return 32'($signed($urandom_range(0, 65536)) - 32768);
        endcase
    endfunction

    // result receiver with random back-pressure
    initial
    begin
        int gap;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                result.ready <= 1'b0;
                repeat (150) @(posedge clk);
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                gap = $urandom_range(1, 5);
                result.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        rating_set_t got, want;
        if (rst_n && result.valid && result.ready)
        begin
            got = {result.visible, result.rating_distance, result.rating_azimuth,
                   result.rating_elevation};
            if (expected_ratings.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = expected_ratings.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: vis %b/%b dist %0d/%0d az %0d/%0d el %0d/%0d",
                                 want.visible, got.visible, want.rd, got.rd,
                                 want.ra, got.ra, want.re, got.re);
                end
            end
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if ((pose.valid && pose.ready) || (result.valid && result.ready)
            || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000 && !timed_out)
        begin
            timed_out = 1'b1;
            $display("FAIL pose_visibility_rating_unit");
            $finish;
        end
    end

    task automatic test_directed;
        set_config(32'd26214, 32'd98304, 16'd15360, 16'd11520, 17'd0, 17'd0, 17'd0);
        send_pose(32'h0, 32'h0, 32'h0);
        send_pose(32'h0, 32'h0, 32'd62259);
        send_pose(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
        send_pose(32'h80000000, 32'h80000000, 32'h80000000);
        send_pose(32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF);
        send_pose(32'd1000, 32'hFFFFFC18, 32'd65536);
        send_pose(32'd65536, 32'd0, 32'hFFFF0000);
        send_pose(32'h80000000, 32'h7FFFFFFF, 32'd0);
        send_pose(32'd0, 32'd0, 32'd26214);
        send_pose(32'd0, 32'd0, 32'd98304);
        // far below near, zero fields of view
        set_config(32'h7FFFFFFF, 32'd0, 16'd0, 16'd0, 17'h0FFFF, 17'h10000, 17'h10000);
        send_pose(32'd0, 32'd0, 32'd65536);
        send_pose(32'd5, 32'd5, 32'h7FFFFFFF);
        // widest band, fields at and above 180, thresholds at one and at minus one
        set_config(32'd0, 32'h7FFFFFFF, 16'hFFFF, 16'd46080, 17'd32768, 17'd32768,
                   17'h1FFFF);
        send_pose(32'd0, 32'd0, 32'h3FFFFFFF);
        send_pose(32'h80000000, 32'h0, 32'h80000000);
        send_pose(32'h0, 32'h0, 32'h0);
        set_config(32'd0, 32'h7FFFFFFF, 16'd46080, 16'd46080, 17'h10000, 17'h10000,
                   17'h10000);
        send_pose(32'h12345678, 32'hEDCBA987, 32'h40000000);
        send_pose(32'h0, 32'h0, 32'h40000000);
    endtask

    task automatic test_random_configs;
        for (int ph = 0; ph < 6; ph++)
        begin
            set_config($urandom_range(0, 200000), $urandom_range(0, 800000),
                       16'($urandom_range(0, 46080)), 16'($urandom_range(0, 46080)),
                       17'($signed($urandom_range(0, 40000)) - 4000),
                       17'($signed($urandom_range(0, 40000)) - 4000),
                       17'($signed($urandom_range(0, 40000)) - 4000));
            repeat (90)
                send_pose(rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic test_backpressure;
        set_config(32'd26214, 32'd98304, 16'd15360, 16'd11520, 17'd0, 17'd0, 17'd0);
        hold_long = 1'b1;
        fork
            begin
                repeat (60) @(posedge clk);
                hold_long = 1'b0;
            end
        join_none
        repeat (100)
            send_pose(rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_full_rate;
        gaps_on = 1'b0;
        repeat (60)
            send_pose(rand_coord(), rand_coord(), rand_coord());
    endtask

    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = pvr_pkg::REG_NEAR;
        cfg.data = '0;
        pose.valid = 1'b0;
        pose.pos_x = '0;
        pose.pos_y = '0;
        pose.pos_z = '0;
        near_q = pvr_pkg::NEAR_RESET;
        far_q = pvr_pkg::FAR_RESET;
        fovh_q = pvr_pkg::FOV_H_RESET;
        fovv_q = pvr_pkg::FOV_V_RESET;
        thr_d = pvr_pkg::THR_RESET;
        thr_a = pvr_pkg::THR_RESET;
        thr_e = pvr_pkg::THR_RESET;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_configs();
        test_backpressure();
        test_full_rate();
        drain();
        if (mismatches == 0 && expected_ratings.size() == 0)
            $display("PASS pose_visibility_rating_unit");
        else
            $display("FAIL pose_visibility_rating_unit");
        $finish;
    end
endmodule

FILE: pose_visibility_rating_unit.f
sv/pvr_pkg.sv
sv/pvr_in_if.sv
sv/pvr_out_if.sv
sv/pvr_cfg_if.sv
sv/pvr_angle.sv
sv/pvr_phase_div.sv
sv/pvr_raised_cos.sv
sv/pose_visibility_rating_unit.sv
tb/sv/tb.sv
